### rtl/sma_pkg.sv
package sma_pkg;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_SWAP = 3'd1,
      OP_ADD  = 3'd2,
      OP_SUB  = 3'd3,
      OP_DIV  = 3'd4,
      OP_MUL  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_SHORT   = 2'd1,
      ST_DIVZERO = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 7;

   typedef struct packed {
      logic [2:0]               req_type;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] top_value;
      logic [COUNT_W-1:0]       stack_count;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       do_push;
      logic       clear;
      logic       read_sec;
      logic       do_swap;
      logic       alu_wb;
      logic       mul_start;
      logic       mul_wb;
      logic       div_start;
      logic       div_step;
      logic       div_wb;
      logic       load_rsp;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       lt2;
      logic       full;
      logic       top_zero;
      logic       div_last;
   } sts_type;

endpackage

### rtl/sma_dpath.sv
module sma_dpath
   import sma_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [WORD_W-1:0] mem [STACK_DEPTH];

   req_type           req_ff, req_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [WORD_W-1:0] top_ff, top_in;
   logic [WORD_W-1:0] rd_ff;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] dsr_ff, dsr_in;
   logic              neg_ff, neg_in;
   logic [4:0]        dcnt_ff, dcnt_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CW-1:0]       cnt_m1, cnt_m2;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [WORD_W-1:0]   prod_low;
   logic [WORD_W:0]     rem_sh;
   logic [WORD_W-1:0]   alu_res;
   logic [PW-1:0]       cnt_pad;

   assign cnt_m1    = cnt_ff - 1'b1;
   assign cnt_m2    = cnt_ff - 2'd2;
   assign mem_we    = (cmd.do_push && (cnt_ff != '0)) || cmd.do_swap;
   assign mem_waddr = cmd.do_push ? cnt_m1[AW-1:0] : cnt_m2[AW-1:0];
   assign prod_low  = rd_ff * top_ff;
   assign rem_sh    = {rem_ff, quo_ff[WORD_W-1]};
   assign alu_res   = (req_ff.req_type == OP_SUB) ? (rd_ff - top_ff) : (rd_ff + top_ff);
   assign cnt_pad   = PW'(cnt_ff);

   always_comb begin
      req_in  = req_ff;
      cnt_in  = cnt_ff;
      top_in  = top_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      dcnt_in = dcnt_ff;
      rsp_in  = rsp_ff;
      if (cmd.capture) begin
         req_in = req_data;
      end
      if (cmd.do_push) begin
         top_in = req_ff.push_value;
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.clear) begin
         cnt_in = '0;
      end
      if (cmd.do_swap) begin
         top_in = rd_ff;
      end
      if (cmd.alu_wb) begin
         top_in = alu_res;
         cnt_in = cnt_m1;
      end
      if (cmd.mul_start) begin
         prod_in = prod_low;
      end
      if (cmd.mul_wb) begin
         top_in = prod_ff;
         cnt_in = cnt_m1;
      end
      if (cmd.div_start) begin
         rem_in  = '0;
         quo_in  = rd_ff[WORD_W-1] ? (-rd_ff) : rd_ff;
         dsr_in  = top_ff[WORD_W-1] ? (-top_ff) : top_ff;
         neg_in  = rd_ff[WORD_W-1] ^ top_ff[WORD_W-1];
         dcnt_in = '0;
      end
      if (cmd.div_step) begin
         dcnt_in = dcnt_ff + 1'b1;
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sh[WORD_W-1:0] - dsr_ff;
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
      end
      if (cmd.div_wb) begin
         top_in = neg_ff ? (-quo_ff) : quo_ff;
         cnt_in = cnt_m1;
      end
      if (cmd.load_rsp) begin
         rsp_in.status      = cmd.status;
         rsp_in.top_value   = (cnt_ff != '0) ? top_ff : '0;
         rsp_in.stack_count = cnt_pad[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      req_ff  <= req_in;
      top_ff  <= top_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
      dcnt_ff <= dcnt_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= top_ff;
      end
      if (cmd.read_sec) begin
         rd_ff <= mem[cnt_m2[AW-1:0]];
      end
   end

   assign sts.op       = req_ff.req_type;
   assign sts.lt2      = (cnt_ff < CW'(2));
   assign sts.full     = (cnt_ff >= CW'(STACK_DEPTH));
   assign sts.top_zero = (top_ff == '0);
   assign sts.div_last = (dcnt_ff == '1);
   assign rsp_data     = rsp_ff;

endmodule

### rtl/sma_ctrl.sv
module sma_ctrl
   import sma_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_FETCH  = 7'b0000100,
      S_MUL    = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_DIVWB  = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.status   = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            state_in  = S_DONE;
            unique case (sts.op)
               OP_PUSH: begin
                  if (sts.full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.do_push = 1'b1;
                  end
               end
               OP_SWAP, OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
                  if (sts.lt2) begin
                     cmd.clear = 1'b1;
                     status_in = ST_SHORT;
                  end else if ((sts.op == OP_DIV) && sts.top_zero) begin
                     cmd.clear = 1'b1;
                     status_in = ST_DIVZERO;
                  end else begin
                     cmd.read_sec = 1'b1;
                     state_in     = S_FETCH;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_FETCH: begin
            state_in = S_DONE;
            unique case (sts.op)
               OP_SWAP: cmd.do_swap = 1'b1;
               OP_ADD, OP_SUB: cmd.alu_wb = 1'b1;
               OP_MUL: begin
                  cmd.mul_start = 1'b1;
                  state_in      = S_MUL;
               end
               OP_DIV: begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_MUL: begin
            cmd.mul_wb = 1'b1;
            state_in   = S_DONE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DIVWB;
            end
         end
         S_DIVWB: begin
            cmd.div_wb = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/stack_machine_alu.sv
// Operand stack of signed 32-bit words running push, swap, add, sub, div and
// mul, one result beat per request beat. The top entry sits in a register and
// the rest in a single-port stack memory, so binary operations first fetch
// the second entry in a fetch state. Push, errors and unknown ops pass decode
// and done; swap/add/sub also fetch, mul fetch and multiply, div fetch, the
// radix-2 restoring divider retiring one quotient bit per cycle and write-back.
// The next request is taken once the previous result is loaded into the output
// register, even while that result is still stalled. Errors (short stack, zero
// divisor) empty the stack; a push on a full stack is refused.
module stack_machine_alu
   import sma_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   sma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sma_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import sma_pkg::*;

   localparam int STACK_DEPTH = 64;
   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 150;
   localparam int REPORT_MAX  = 10;

   localparam logic [2:0]  OP_SPARE_6 = 3'd6;
   localparam logic [2:0]  OP_SPARE_7 = 3'd7;
   localparam logic [31:0] WORD_MIN   = 32'h8000_0000;
   localparam logic [31:0] WORD_MAX   = 32'h7fff_ffff;
   localparam logic [31:0] WORD_ONE   = 32'd1;
   localparam logic [31:0] WORD_M1    = 32'hffff_ffff;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [31:0] stack_words [STACK_DEPTH];
   int unsigned words_held   = 0;
   rsp_type     results_due [$];
   int          mismatches   = 0;
   bit          idle_on      = 1'b1;
   bit          hold_request = 1'b0;

   stack_machine_alu #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] quotient_trunc(logic [31:0] num, logic [31:0] den);
      logic [31:0] mag_num;
      logic [31:0] mag_den;
      logic [31:0] mag_q;
      mag_num = num[31] ? -num : num;
      mag_den = den[31] ? -den : den;
      mag_q   = mag_num / mag_den;
      return (num[31] != den[31]) ? -mag_q : mag_q;
   endfunction

   function automatic rsp_type apply_stack_op(logic [2:0] op, logic [31:0] value);
      rsp_type    r;
      status_type st;
      logic [31:0] top;
      logic [31:0] sec;
      logic [31:0] res;
      st = ST_OK;
      if (op == OP_PUSH) begin
         if (words_held >= STACK_DEPTH) begin
            st = ST_FULL;
         end else begin
            stack_words[words_held] = value;
            words_held++;
         end
      end else if (op <= OP_MUL) begin
         if (words_held < 2) begin
            st = ST_SHORT;
            words_held = 0;
         end else begin
            top = stack_words[words_held-1];
            sec = stack_words[words_held-2];
            if (op == OP_SWAP) begin
               stack_words[words_held-1] = sec;
               stack_words[words_held-2] = top;
            end else if (op == OP_DIV && top == '0) begin
               st = ST_DIVZERO;
               words_held = 0;
            end else begin
               case (op)
                  OP_ADD:  res = sec + top;
                  OP_SUB:  res = sec - top;
                  OP_DIV:  res = quotient_trunc(sec, top);
                  default: res = sec * top;
               endcase
               stack_words[words_held-2] = res;
               words_held--;
            end
         end
      end
      r.status      = st;
      r.top_value   = (words_held > 0) ? stack_words[words_held-1] : '0;
      r.stack_count = COUNT_W'(words_held);
      return r;
   endfunction

   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      case ($urandom_range(0, 4))
         0: w = $urandom;
         1: w = $urandom_range(0, 16) - 32'd8;
         2: begin
            case ($urandom_range(0, 4))
               0:       w = WORD_MIN;
               1:       w = WORD_MAX;
               2:       w = '0;
               3:       w = WORD_M1;
               default: w = WORD_ONE;
            endcase
         end
         3: w = $urandom >> $urandom_range(0, 31);
         default: w = -($urandom >> $urandom_range(0, 31));
      endcase
      return w;
   endfunction

   task automatic send_beat(input logic [2:0] op, input logic [31:0] value);
      req_type beat;
      beat.req_type   = op;
      beat.push_value = value;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      results_due.push_back(apply_stack_op(op, value));
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed_ops();
      send_beat(OP_SWAP, rand_word());
      send_beat(OP_PUSH, WORD_MAX);
      send_beat(OP_ADD, rand_word());
      send_beat(OP_PUSH, WORD_MAX);
      send_beat(OP_PUSH, WORD_ONE);
      send_beat(OP_ADD, '0);
      send_beat(OP_PUSH, WORD_ONE);
      send_beat(OP_SUB, '0);
      send_beat(OP_PUSH, WORD_MIN);
      send_beat(OP_PUSH, WORD_M1);
      send_beat(OP_DIV, '0);
      send_beat(OP_PUSH, -32'd7);
      send_beat(OP_PUSH, 32'd2);
      send_beat(OP_DIV, '0);
      send_beat(OP_PUSH, 32'h0001_0000);
      send_beat(OP_PUSH, 32'h0001_0000);
      send_beat(OP_MUL, '0);
      send_beat(OP_MUL, '0);
      send_beat(OP_PUSH, 32'd9);
      send_beat(OP_SWAP, WORD_M1);
      send_beat(OP_SUB, '0);
      send_beat(OP_SPARE_6, WORD_M1);
      send_beat(OP_SPARE_7, WORD_MIN);
      send_beat(OP_PUSH, '0);
      send_beat(OP_DIV, '0);
   endtask

   task automatic test_full_stack_backpressure();
      // empty the stack with a short-stack divide, then fill it while results back up
      send_beat(OP_PUSH, '0);
      send_beat(OP_DIV, rand_word());
      hold_request = 1'b1;
      repeat (STACK_DEPTH + 2) send_beat(OP_PUSH, rand_word());
      send_beat(OP_SWAP, rand_word());
      send_beat(OP_MUL, rand_word());
      send_beat(OP_PUSH, rand_word());
      send_beat(OP_PUSH, rand_word());
   endtask

   task automatic test_random_programs(input int n_items, input int push_pct);
      logic [2:0] op;
      int         pick;
      repeat (n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
         end else if (pick < 8) begin
            op = 3'($urandom_range(OP_PUSH, OP_MUL));
         end else if (words_held < 2 || (pick < 8 + push_pct && words_held < STACK_DEPTH)) begin
            op = OP_PUSH;
         end else if (words_held >= STACK_DEPTH && pick < 20) begin
            op = OP_PUSH;
         end else begin
            op = 3'($urandom_range(OP_SWAP, OP_MUL));
         end
         send_beat(op, rand_word());
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("result beat with nothing due: %p", rsp_data);
         end else begin
            want = results_due.pop_front();
            if (rsp_data.status !== want.status || rsp_data.top_value !== want.top_value ||
                rsp_data.stack_count !== want.stack_count) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("mismatch: status %0d/%0d top %0d/%0d count %0d/%0d (exp/act)",
                           want.status, rsp_data.status, want.top_value, rsp_data.top_value,
                           want.stack_count, rsp_data.stack_count);
            end
         end
      end
   end

   initial begin : rsp_pacing
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 20)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_ops();
      test_full_stack_backpressure();
      test_random_programs(280, 42);
      test_random_programs(110, 70);
      idle_on = 1'b0;
      test_random_programs(90, 42);
      release_req();
      while (results_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
